// ----- hw/rtl/incidence_matrix_neighbor_query_assert.svh -----
// Assertion macros shared by the incidence matrix block
`ifndef INCIDENCE_MATRIX_NEIGHBOR_QUERY_ASSERT_SVH
`define INCIDENCE_MATRIX_NEIGHBOR_QUERY_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define IMNQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IMNQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/imnq_pkg.sv -----
// Shared types and constants of the incidence matrix neighbor query block
package imnq_pkg;

    localparam int VERT_W    = 7;
    localparam int EDGE_W    = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int REQ_W     = 2;
    localparam int CELL_W    = 2;

    localparam int DEF_MAX_VERTS     = 64;
    localparam int DEF_MAX_EDGE_COLS = 64;

    localparam logic [CFG_W-1:0]  RST_VERTEX_COUNT = 7'd64;
    localparam logic [CFG_W-1:0]  RST_EDGE_COUNT   = 7'd0;
    localparam logic [CELL_W-1:0] CELL_ONE         = 2'd1;
    localparam logic [CELL_W-1:0] CELL_MAX         = 2'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_ADJ   = 2'd2,
        REQ_NBR   = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_EDGE_COUNT   = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RA,
        ST_ADD_WA,
        ST_ADD_RB,
        ST_ADD_WB,
        ST_ADJ_RA,
        ST_ADJ_LA,
        ST_ADJ_OUT,
        ST_NB_RA,
        ST_NB_LA,
        ST_NB_SCAN,
        ST_NB_END
    } t_state;

    typedef enum logic [2:0] {
        RD_A,
        RD_B,
        RD_Y0,
        RD_Y,
        RD_YNEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        OUT_ADJ,
        OUT_PEND,
        OUT_END
    } t_out_kind;

    typedef struct packed {
        logic      latch_req;
        logic      clear_all;
        t_rd_sel   rd_sel;
        logic      wr_en;
        logic      wr_sel_b;
        logic      load_row_a;
        logic      y_init;
        logic      y_step;
        logic      pend_set;
        logic      out_load;
        t_out_kind out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic pend_vld;
        logic y_last;
        logic nv_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hw/rtl/incidence_matrix_neighbor_query.sv -----
// Top level of the incidence matrix neighbor query block
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    req_type, edge_index, vertex_a, vertex_b
//   result    out        o_out_valid / i_out_ready  neighbor_vertex, is_adjacent, found, last
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Clear completes on acceptance; add edge reads and writes row A, then row B;
// adjacency query loads row A, compares it with row B and waits for the output.
// Neighbor query scans min(vertex_count, MAX_VERTS) rows, one stored row per
// cycle unless stalled, through the single read port of the row RAM. Reset and
// clear invalidate all rows at once through per-row valid bits. A full result
// register stalls the neighbor scan only when a second match is found; otherwise the scan keeps going.
module incidence_matrix_neighbor_query #(
    parameter int MAX_VERTS     = imnq_pkg::DEF_MAX_VERTS,
    parameter int MAX_EDGE_COLS = imnq_pkg::DEF_MAX_EDGE_COLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [imnq_pkg::REQ_W-1:0]     i_req_type,
    input  logic [imnq_pkg::EDGE_W-1:0]    i_edge_index,
    input  logic [imnq_pkg::VERT_W-1:0]    i_vertex_a,
    input  logic [imnq_pkg::VERT_W-1:0]    i_vertex_b,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [imnq_pkg::VERT_W-1:0]    o_neighbor_vertex,
    output logic                           o_is_adjacent,
    output logic                           o_found,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic [imnq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [imnq_pkg::CFG_W-1:0]     i_cfg_data
);

    imnq_pkg::t_dp_cmd w_cmd;
    imnq_pkg::t_dp_sts w_sts;
    logic              w_clear_acc;
    logic              w_found_vld;
    logic              w_found_ok;
    logic              w_none_vld;
    logic              w_none_ok;

    imnq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    imnq_dp #(
        .MAX_VERTS     (MAX_VERTS),
        .MAX_EDGE_COLS (MAX_EDGE_COLS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_edge_index      (i_edge_index),
        .i_vertex_a        (i_vertex_a),
        .i_vertex_b        (i_vertex_b),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_neighbor_vertex (o_neighbor_vertex),
        .o_is_adjacent     (o_is_adjacent),
        .o_found           (o_found),
        .o_last            (o_last)
    );

    assign w_clear_acc = i_in_valid && o_in_ready && (i_req_type == imnq_pkg::REQ_CLEAR);
    assign w_found_vld = o_out_valid && o_found;
    assign w_found_ok  = o_is_adjacent && (o_neighbor_vertex != '0);
    assign w_none_vld  = o_out_valid && !o_found;
    assign w_none_ok   = (o_neighbor_vertex == '0) && o_last;

`include "incidence_matrix_neighbor_query_assert.svh"

    `IMNQ_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, w_sts.out_free, "lost result")
    `IMNQ_ASSERT_IMPLY(a_found_is_real, i_clk, i_rst_n, w_found_vld, w_found_ok, "bad neighbor")
    `IMNQ_ASSERT_IMPLY(a_none_is_last, i_clk, i_rst_n, w_none_vld, w_none_ok, "none not last")
    `IMNQ_ASSERT_NEXT(a_clear_one_cycle, i_clk, i_rst_n, w_clear_acc, o_in_ready, "clear stuck")

endmodule

// ----- hw/rtl/imnq_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module imnq_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/imnq_ctrl.sv -----
// Request sequencer of the incidence matrix block
module imnq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [imnq_pkg::REQ_W-1:0]    i_req_type,
    input  imnq_pkg::t_dp_sts             i_sts,
    output imnq_pkg::t_dp_cmd             o_cmd
);

    imnq_pkg::t_state r_state;
    imnq_pkg::t_state n_state;
    imnq_pkg::t_req   w_req;
    logic             w_accept;
    logic             w_stall;

    assign w_req    = imnq_pkg::t_req'(i_req_type);
    assign w_accept = i_in_valid && (r_state == imnq_pkg::ST_IDLE);
    // a found neighbor can only be taken once the previous one has left
    assign w_stall  = i_sts.hit && i_sts.pend_vld && !i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imnq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            imnq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_req)
                        imnq_pkg::REQ_CLEAR: n_state = imnq_pkg::ST_IDLE;
                        imnq_pkg::REQ_ADD:   n_state = imnq_pkg::ST_ADD_RA;
                        imnq_pkg::REQ_ADJ:   n_state = imnq_pkg::ST_ADJ_RA;
                        imnq_pkg::REQ_NBR:   n_state = imnq_pkg::ST_NB_RA;
                        default:             n_state = imnq_pkg::ST_IDLE;
                    endcase
                end
            end
            imnq_pkg::ST_ADD_RA:  n_state = imnq_pkg::ST_ADD_WA;
            imnq_pkg::ST_ADD_WA:  n_state = imnq_pkg::ST_ADD_RB;
            imnq_pkg::ST_ADD_RB:  n_state = imnq_pkg::ST_ADD_WB;
            imnq_pkg::ST_ADD_WB:  n_state = imnq_pkg::ST_IDLE;
            imnq_pkg::ST_ADJ_RA:  n_state = imnq_pkg::ST_ADJ_LA;
            imnq_pkg::ST_ADJ_LA:  n_state = imnq_pkg::ST_ADJ_OUT;
            imnq_pkg::ST_ADJ_OUT: begin
                if (i_sts.out_free) begin
                    n_state = imnq_pkg::ST_IDLE;
                end
            end
            imnq_pkg::ST_NB_RA:   n_state = imnq_pkg::ST_NB_LA;
            imnq_pkg::ST_NB_LA: begin
                n_state = i_sts.nv_zero ? imnq_pkg::ST_NB_END : imnq_pkg::ST_NB_SCAN;
            end
            imnq_pkg::ST_NB_SCAN: begin
                if (!w_stall && i_sts.y_last) begin
                    n_state = imnq_pkg::ST_NB_END;
                end
            end
            imnq_pkg::ST_NB_END: begin
                if (i_sts.out_free) begin
                    n_state = imnq_pkg::ST_IDLE;
                end
            end
            default: n_state = imnq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.rd_sel   = imnq_pkg::RD_A;
        o_cmd.out_kind = imnq_pkg::OUT_ADJ;
        o_in_ready = 1'b0;
        case (r_state)
            imnq_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.latch_req = w_accept;
                o_cmd.clear_all = w_accept && (w_req == imnq_pkg::REQ_CLEAR);
            end
            imnq_pkg::ST_ADD_RA: o_cmd.rd_sel = imnq_pkg::RD_A;
            imnq_pkg::ST_ADD_WA: o_cmd.wr_en  = 1'b1;
            imnq_pkg::ST_ADD_RB: o_cmd.rd_sel = imnq_pkg::RD_B;
            imnq_pkg::ST_ADD_WB: begin
                o_cmd.rd_sel   = imnq_pkg::RD_B;
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_sel_b = 1'b1;
            end
            imnq_pkg::ST_ADJ_RA: o_cmd.rd_sel = imnq_pkg::RD_A;
            imnq_pkg::ST_ADJ_LA: begin
                o_cmd.load_row_a = 1'b1;
                o_cmd.rd_sel     = imnq_pkg::RD_B;
            end
            imnq_pkg::ST_ADJ_OUT: begin
                o_cmd.rd_sel   = imnq_pkg::RD_B;
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_kind = imnq_pkg::OUT_ADJ;
            end
            imnq_pkg::ST_NB_RA: o_cmd.rd_sel = imnq_pkg::RD_A;
            imnq_pkg::ST_NB_LA: begin
                o_cmd.load_row_a = 1'b1;
                o_cmd.y_init     = 1'b1;
                o_cmd.rd_sel     = imnq_pkg::RD_Y0;
            end
            imnq_pkg::ST_NB_SCAN: begin
                // hold the row address while stalled so the read data stays put
                o_cmd.rd_sel   = (w_stall || i_sts.y_last) ? imnq_pkg::RD_Y
                                                           : imnq_pkg::RD_YNEXT;
                o_cmd.y_step   = !w_stall && !i_sts.y_last;
                o_cmd.pend_set = !w_stall && i_sts.hit;
                o_cmd.out_load = !w_stall && i_sts.hit && i_sts.pend_vld;
                o_cmd.out_kind = imnq_pkg::OUT_PEND;
            end
            imnq_pkg::ST_NB_END: begin
                o_cmd.rd_sel   = imnq_pkg::RD_Y;
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_kind = imnq_pkg::OUT_END;
            end
            default: o_cmd.rd_sel = imnq_pkg::RD_A;
        endcase
    end

endmodule

// ----- hw/rtl/imnq_dp.sv -----
// Datapath: row store, config registers, column compare and result register
module imnq_dp #(
    parameter int MAX_VERTS     = imnq_pkg::DEF_MAX_VERTS,
    parameter int MAX_EDGE_COLS = imnq_pkg::DEF_MAX_EDGE_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  imnq_pkg::t_dp_cmd                i_cmd,
    output imnq_pkg::t_dp_sts                o_sts,
    input  logic [imnq_pkg::EDGE_W-1:0]      i_edge_index,
    input  logic [imnq_pkg::VERT_W-1:0]      i_vertex_a,
    input  logic [imnq_pkg::VERT_W-1:0]      i_vertex_b,
    input  logic                             i_cfg_we,
    input  logic [imnq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [imnq_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [imnq_pkg::VERT_W-1:0]      o_neighbor_vertex,
    output logic                             o_is_adjacent,
    output logic                             o_found,
    output logic                             o_last
);

    localparam int RW    = $clog2(MAX_VERTS);
    localparam int ROW_W = imnq_pkg::CELL_W * MAX_EDGE_COLS;
    localparam int CW    = imnq_pkg::CELL_W;
    localparam int VW    = imnq_pkg::VERT_W;

    logic [imnq_pkg::EDGE_W-1:0] r_edge_index;
    logic [VW-1:0]               r_vertex_a;
    logic [VW-1:0]               r_vertex_b;
    logic [imnq_pkg::CFG_W-1:0]  r_vertex_count;
    logic [imnq_pkg::CFG_W-1:0]  r_edge_count;
    logic [MAX_VERTS-1:0]        r_row_vld;
    logic                        r_rd_vld;
    logic [ROW_W-1:0]            r_row_a;
    logic [RW-1:0]               r_y;
    logic                        r_pend_vld;
    logic [VW-1:0]               r_pend_vtx;
    logic                        r_out_vld;
    logic [VW-1:0]               r_out_nv;
    logic                        r_out_adj;
    logic                        r_out_found;
    logic                        r_out_last;

    logic [VW-1:0]         w_a_m1;
    logic [VW-1:0]         w_b_m1;
    logic [RW-1:0]         w_a_idx;
    logic [RW-1:0]         w_b_idx;
    logic                  w_a_ok;
    logic                  w_b_ok;
    logic                  w_col_ok;
    logic [RW-1:0]         w_raddr;
    logic [RW-1:0]         w_waddr;
    logic                  w_we;
    logic [ROW_W-1:0]      w_rd_row;
    logic [ROW_W-1:0]      w_row_eff;
    logic [ROW_W-1:0]      w_row_new;
    logic [ROW_W-1:0]      w_row_masked;
    logic [MAX_EDGE_COLS-1:0] w_hit_col;
    logic [VW-1:0]         w_nv_lim;
    logic [VW-1:0]         w_y_vtx;
    logic                  w_out_free;

    assign w_a_m1   = r_vertex_a - VW'(1);
    assign w_b_m1   = r_vertex_b - VW'(1);
    assign w_a_idx  = w_a_m1[RW-1:0];
    assign w_b_idx  = w_b_m1[RW-1:0];
    assign w_a_ok   = (r_vertex_a != '0) && (r_vertex_a <= VW'(MAX_VERTS));
    assign w_b_ok   = (r_vertex_b != '0) && (r_vertex_b <= VW'(MAX_VERTS));
    assign w_col_ok = (r_edge_index != '0) && (int'(r_edge_index) <= MAX_EDGE_COLS);

    always_comb begin
        case (i_cmd.rd_sel)
            imnq_pkg::RD_A:     w_raddr = w_a_idx;
            imnq_pkg::RD_B:     w_raddr = w_b_idx;
            imnq_pkg::RD_Y0:    w_raddr = '0;
            imnq_pkg::RD_Y:     w_raddr = r_y;
            imnq_pkg::RD_YNEXT: w_raddr = r_y + RW'(1);
            default:            w_raddr = w_a_idx;
        endcase
    end

    assign w_waddr = i_cmd.wr_sel_b ? w_b_idx : w_a_idx;
    // out-of-range column leaves the store untouched; out-of-range endpoint skips only its own row
    assign w_we    = i_cmd.wr_en && w_col_ok && (i_cmd.wr_sel_b ? w_b_ok : w_a_ok);

    imnq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VERTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_row_new),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_row)
    );

    // a row never written since the last clear reads as zero
    assign w_row_eff = r_rd_vld ? w_rd_row : '0;

    always_comb begin
        logic [CW-1:0] v_cell;
        for (int c = 0; c < MAX_EDGE_COLS; c++) begin
            v_cell = w_row_eff[c*CW +: CW];
            w_row_masked[c*CW +: CW] = (c < int'(r_edge_count)) ? v_cell : '0;
            w_hit_col[c] = (r_row_a[c*CW +: CW] == imnq_pkg::CELL_ONE) &&
                           (v_cell == imnq_pkg::CELL_ONE);
            if ((c == int'(r_edge_index) - 1) && (v_cell != imnq_pkg::CELL_MAX)) begin
                w_row_new[c*CW +: CW] = v_cell + CW'(1);
            end else begin
                w_row_new[c*CW +: CW] = v_cell;
            end
        end
    end

    assign w_nv_lim   = (r_vertex_count > VW'(MAX_VERTS)) ? VW'(MAX_VERTS) : r_vertex_count;
    assign w_y_vtx    = VW'(r_y) + VW'(1);
    assign w_out_free = !r_out_vld || i_out_ready;

    assign o_sts.hit      = |w_hit_col;
    assign o_sts.pend_vld = r_pend_vld;
    assign o_sts.y_last   = (w_y_vtx == w_nv_lim);
    assign o_sts.nv_zero  = (r_vertex_count == '0);
    assign o_sts.out_free = w_out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= imnq_pkg::RST_VERTEX_COUNT;
            r_edge_count   <= imnq_pkg::RST_EDGE_COUNT;
            r_row_vld      <= '0;
            r_rd_vld       <= 1'b0;
            r_pend_vld     <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (imnq_pkg::t_cfg_reg'(i_cfg_index))
                    imnq_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                    imnq_pkg::CFG_EDGE_COUNT:   r_edge_count   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear_all) begin
                r_row_vld <= '0;
            end else if (w_we) begin
                r_row_vld[w_waddr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[w_raddr];
            if (i_cmd.latch_req) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.pend_set) begin
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_edge_index <= i_edge_index;
            r_vertex_a   <= i_vertex_a;
            r_vertex_b   <= i_vertex_b;
        end
        if (i_cmd.load_row_a) begin
            r_row_a <= w_a_ok ? w_row_masked : '0;
        end
        if (i_cmd.y_init) begin
            r_y <= '0;
        end else if (i_cmd.y_step) begin
            r_y <= r_y + RW'(1);
        end
        if (i_cmd.pend_set) begin
            r_pend_vtx <= w_y_vtx;
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                imnq_pkg::OUT_ADJ: begin
                    r_out_nv    <= '0;
                    r_out_adj   <= o_sts.hit && w_b_ok;
                    r_out_found <= 1'b0;
                    r_out_last  <= 1'b1;
                end
                imnq_pkg::OUT_PEND: begin
                    r_out_nv    <= r_pend_vtx;
                    r_out_adj   <= 1'b1;
                    r_out_found <= 1'b1;
                    r_out_last  <= 1'b0;
                end
                imnq_pkg::OUT_END: begin
                    r_out_nv    <= r_pend_vld ? r_pend_vtx : '0;
                    r_out_adj   <= r_pend_vld;
                    r_out_found <= r_pend_vld;
                    r_out_last  <= 1'b1;
                end
                default: begin
                    r_out_nv    <= '0;
                    r_out_adj   <= 1'b0;
                    r_out_found <= 1'b0;
                    r_out_last  <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_neighbor_vertex = r_out_nv;
    assign o_is_adjacent     = r_out_adj;
    assign o_found           = r_out_found;
    assign o_last            = r_out_last;

endmodule

// ----- verif/incidence_matrix_neighbor_query_tb.sv -----
// Self-checking testbench for the incidence matrix neighbor query block
`timescale 1ns / 1ps

module incidence_matrix_neighbor_query_tb;

    localparam int MAX_VERTS   = imnq_pkg::DEF_MAX_VERTS;
    localparam int MAX_COLS    = imnq_pkg::DEF_MAX_EDGE_COLS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [imnq_pkg::VERT_W-1:0] neighbor_vertex;
        logic                        is_adjacent;
        logic                        found;
        logic                        last;
    } t_answer;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_valid;
    logic                           o_in_ready;
    logic [imnq_pkg::REQ_W-1:0]     req_type;
    logic [imnq_pkg::EDGE_W-1:0]    edge_index;
    logic [imnq_pkg::VERT_W-1:0]    vertex_a;
    logic [imnq_pkg::VERT_W-1:0]    vertex_b;
    logic                           o_out_valid;
    logic                           out_ready;
    logic [imnq_pkg::VERT_W-1:0]    o_neighbor_vertex;
    logic                           o_is_adjacent;
    logic                           o_found;
    logic                           o_last;
    logic                           cfg_we;
    logic [imnq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [imnq_pkg::CFG_W-1:0]     cfg_data;

    // local copy of the incidence matrix and registers
    logic [imnq_pkg::CELL_W-1:0] cell_cnt [1:MAX_VERTS][1:MAX_COLS];
    int                          vertex_cfg;
    int                          edge_cfg;

    t_answer answer_q[$];
    int      mismatch_cnt;
    int      cycle_cnt;
    bit      idle_on;
    int      stall_left;
    t_answer got_answer;
    t_answer want_answer;

    incidence_matrix_neighbor_query i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (req_type),
        .i_edge_index      (edge_index),
        .i_vertex_a        (vertex_a),
        .i_vertex_b        (vertex_b),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_neighbor_vertex (o_neighbor_vertex),
        .o_is_adjacent     (o_is_adjacent),
        .o_found           (o_found),
        .o_last            (o_last),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- matrix predictor ----------------

    function automatic bit vertex_ok(int v);
        return (v >= 1) && (v <= MAX_VERTS);
    endfunction

    function automatic void clear_cells();
        for (int v = 1; v <= MAX_VERTS; v++)
            for (int c = 1; c <= MAX_COLS; c++)
                cell_cnt[v][c] = '0;
    endfunction

    function automatic void bump_cell(int v, int c);
        if (vertex_ok(v) && cell_cnt[v][c] != imnq_pkg::CELL_MAX)
            cell_cnt[v][c] = cell_cnt[v][c] + 1'b1;
    endfunction

    function automatic bit shares_edge(int x, int y);
        int cols;
        if (!vertex_ok(x) || !vertex_ok(y))
            return 1'b0;
        cols = (edge_cfg > MAX_COLS) ? MAX_COLS : edge_cfg;
        for (int c = 1; c <= cols; c++)
            if (cell_cnt[x][c] == imnq_pkg::CELL_ONE && cell_cnt[y][c] == imnq_pkg::CELL_ONE)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_answer make_answer(int nbr, bit adj, bit fnd, bit lst);
        t_answer r;
        r.neighbor_vertex = nbr[imnq_pkg::VERT_W-1:0];
        r.is_adjacent     = adj;
        r.found           = fnd;
        r.last            = lst;
        return r;
    endfunction

    function automatic void queue_answer(t_answer ans);
        answer_q.insert(answer_q.size(), ans);
    endfunction

    function automatic string answer_text(t_answer ans);
        return $sformatf("nbr=%0d adj=%0b found=%0b last=%0b",
                         ans.neighbor_vertex, ans.is_adjacent, ans.found, ans.last);
    endfunction

    function automatic void predict_request(imnq_pkg::t_req rq, int col, int a, int b);
        int nv;
        int last_y;
        case (rq)
            imnq_pkg::REQ_CLEAR: clear_cells();
            imnq_pkg::REQ_ADD: begin
                if (col >= 1 && col <= MAX_COLS) begin
                    bump_cell(a, col);
                    bump_cell(b, col);
                end
            end
            imnq_pkg::REQ_ADJ: queue_answer(make_answer(0, shares_edge(a, b), 1'b0, 1'b1));
            default: begin
                nv = (vertex_cfg > MAX_VERTS) ? MAX_VERTS : vertex_cfg;
                last_y = 0;
                for (int y = 1; y <= nv; y++)
                    if (shares_edge(a, y))
                        last_y = y;
                if (last_y == 0) begin
                    queue_answer(make_answer(0, 1'b0, 1'b0, 1'b1));
                end else begin
                    for (int y = 1; y <= last_y; y++)
                        if (shares_edge(a, y))
                            queue_answer(make_answer(y, 1'b1, 1'b1, y == last_y));
                end
            end
        endcase
    endfunction

    // ---------------- drivers ----------------

    // one request transaction; valid stays up after acceptance
    task automatic send_req(imnq_pkg::t_req rq, int col, int a, int b);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        edge_index <= col[imnq_pkg::EDGE_W-1:0];
        vertex_a   <= a[imnq_pkg::VERT_W-1:0];
        vertex_b   <= b[imnq_pkg::VERT_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(rq, col & 'h7f, a & 'h7f, b & 'h7f);
    endtask

    // stop sending and wait until the block has gone quiet
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(imnq_pkg::t_cfg_reg idx, int val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[imnq_pkg::CFG_W-1:0];
        if (idx == imnq_pkg::CFG_VERTEX_COUNT)
            vertex_cfg = val & 'h7f;
        else
            edge_cfg = val & 'h7f;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int vc, int ec);
        drain_results();
        write_reg(imnq_pkg::CFG_VERTEX_COUNT, vc);
        write_reg(imnq_pkg::CFG_EDGE_COUNT, ec);
    endtask

    // result side: random stall bursts while idling is enabled
    initial begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (idle_on && stall_left > 0) begin
                out_ready  <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 6);
            end
        end
    end

    // ---------------- checking ----------------

    task automatic note_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            got_answer = make_answer(int'(o_neighbor_vertex), o_is_adjacent, o_found, o_last);
            if (answer_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result %s", answer_text(got_answer)));
            end else begin
                want_answer = answer_q.pop_front();
                if (got_answer !== want_answer)
                    note_mismatch($sformatf("exp %s, got %s",
                        answer_text(want_answer), answer_text(got_answer)));
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("incidence_matrix_neighbor_query_tb: FAIL");
        $finish;
    end

    // ---------------- tests ----------------

    // registers at reset: edge_count 0 hides every edge
    task automatic test_reset_values();
        send_req(imnq_pkg::REQ_ADD, 1, 1, 2);
        send_req(imnq_pkg::REQ_ADJ, 0, 1, 2);
        send_req(imnq_pkg::REQ_NBR, 127, 1, 0);
    endtask

    task automatic test_directed_requests();
        set_config(MAX_VERTS, MAX_COLS);
        send_req(imnq_pkg::REQ_ADD, 64, 64, 63);
        send_req(imnq_pkg::REQ_ADD, 2, 5, 5);        // self-loop, cell reaches 2
        send_req(imnq_pkg::REQ_ADD, 0, 3, 4);        // column out of range
        send_req(imnq_pkg::REQ_ADD, 65, 3, 4);
        send_req(imnq_pkg::REQ_ADD, 127, 3, 4);
        send_req(imnq_pkg::REQ_ADD, 3, 0, 7);        // one endpoint out of range
        send_req(imnq_pkg::REQ_ADD, 4, 127, 8);
        repeat (4) send_req(imnq_pkg::REQ_ADD, 5, 10, 11);  // saturates at 3
        send_req(imnq_pkg::REQ_ADJ, 127, 1, 2);
        send_req(imnq_pkg::REQ_ADJ, 0, 1, 1);
        send_req(imnq_pkg::REQ_ADJ, 0, 5, 5);
        send_req(imnq_pkg::REQ_ADJ, 0, 64, 63);
        send_req(imnq_pkg::REQ_ADJ, 0, 0, 7);
        send_req(imnq_pkg::REQ_ADJ, 0, 10, 11);
        send_req(imnq_pkg::REQ_ADJ, 0, 127, 8);
        send_req(imnq_pkg::REQ_NBR, 0, 1, 127);
        send_req(imnq_pkg::REQ_NBR, 0, 64, 0);
        send_req(imnq_pkg::REQ_NBR, 0, 0, 1);
        send_req(imnq_pkg::REQ_NBR, 0, 127, 1);
        send_req(imnq_pkg::REQ_CLEAR, 127, 127, 127);
        send_req(imnq_pkg::REQ_NBR, 0, 1, 0);
    endtask

    task automatic test_register_extremes();
        send_req(imnq_pkg::REQ_CLEAR, 0, 0, 0);
        send_req(imnq_pkg::REQ_ADD, 1, 1, 2);
        send_req(imnq_pkg::REQ_ADD, 64, 1, 64);
        set_config(0, MAX_COLS);
        send_req(imnq_pkg::REQ_NBR, 0, 1, 0);
        set_config(1, MAX_COLS);
        send_req(imnq_pkg::REQ_NBR, 0, 1, 0);
        set_config(127, 1);
        send_req(imnq_pkg::REQ_ADJ, 0, 1, 64);
        send_req(imnq_pkg::REQ_ADJ, 0, 1, 2);
        send_req(imnq_pkg::REQ_NBR, 0, 1, 0);
        set_config(127, 127);
        send_req(imnq_pkg::REQ_ADJ, 0, 1, 64);
        send_req(imnq_pkg::REQ_NBR, 0, 1, 0);
    endtask

    function automatic int pick_vertex(int pool);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 127);
        return $urandom_range(1, pool);
    endfunction

    task automatic test_random_traffic(int n_items, int pool, int col_pool, bit with_pause);
        int r;
        int a;
        int b;
        int col;
        for (int i = 0; i < n_items; i++) begin
            if (with_pause && i == n_items / 2)
                drain_results();
            r = $urandom_range(0, 99);
            a = pick_vertex(pool);
            b = ($urandom_range(0, 19) == 0) ? a : pick_vertex(pool);
            col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(1, col_pool);
            if (r < 5)
                send_req(imnq_pkg::t_req'($urandom_range(0, 3)), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 127));
            else if (r < 8)
                send_req(imnq_pkg::REQ_CLEAR, col, a, b);
            else if (r < 52)
                send_req(imnq_pkg::REQ_ADD, col, a, b);
            else if (r < 76)
                send_req(imnq_pkg::REQ_ADJ, col, a, b);
            else
                send_req(imnq_pkg::REQ_NBR, col, a, b);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        req_type     = '0;
        edge_index   = '0;
        vertex_a     = '0;
        vertex_b     = '0;
        cfg_we       = 1'b0;
        cfg_index    = imnq_pkg::CFG_VERTEX_COUNT;
        cfg_data     = '0;
        idle_on      = 1'b1;
        mismatch_cnt = 0;
        vertex_cfg   = int'(imnq_pkg::RST_VERTEX_COUNT);
        edge_cfg     = int'(imnq_pkg::RST_EDGE_COUNT);
        clear_cells();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_requests();
        test_register_extremes();

        set_config(MAX_VERTS, MAX_COLS);
        test_random_traffic(140, 12, 8, 1'b1);
        set_config($urandom_range(1, MAX_VERTS), $urandom_range(0, MAX_COLS));
        test_random_traffic(90, 10, 6, 1'b0);
        set_config($urandom_range(0, 127), $urandom_range(0, 127));
        test_random_traffic(80, 16, 12, 1'b0);

        // back-to-back traffic, no idling on either side
        drain_results();
        idle_on = 1'b0;
        set_config(MAX_VERTS, MAX_COLS);
        test_random_traffic(90, 12, 8, 1'b0);

        drain_results();
        if (answer_q.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived", answer_q.size()));
        if (mismatch_cnt == 0)
            $display("incidence_matrix_neighbor_query_tb: PASS");
        else
            $display("incidence_matrix_neighbor_query_tb: FAIL");
        $finish;
    end

endmodule
